// ===== rtl/sbht_pkg.sv =====
// ----------------------------------------------------------------------------
// sbht_pkg: shared types and constants of the stepper bank tracker
// Opcodes, sequencer states, default sizes and the half-step coil table.
// ----------------------------------------------------------------------------
package sbht_pkg;

  localparam int NUM_MOTORS_DEF = 22;
  localparam int POS_WIDTH_DEF  = 16;
  localparam int PHASE_W        = 3;   // eight half-step phases
  localparam int COIL_W         = 4;
  localparam int MASK_W         = 22;
  localparam int MOTOR_W        = 5;
  localparam int VALUE_W        = 16;
  localparam int OP_W           = 2;
  localparam int CMD_FIFO_DEPTH = 4;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 2'd0,
    OP_SET_TGT = 2'd1,
    OP_SET_POS = 2'd2,
    OP_READ    = 2'd3
  } cmd_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC
  } back_state_t;

  // Half-step coil drive; bit 3 is the first coil.
  function automatic logic [COIL_W-1:0] coil_of(input logic [PHASE_W-1:0] ph);
    logic [COIL_W-1:0] c;
    unique case (ph)
      3'd0: c = 4'd8;
      3'd1: c = 4'd12;
      3'd2: c = 4'd4;
      3'd3: c = 4'd6;
      3'd4: c = 4'd2;
      3'd5: c = 4'd3;
      3'd6: c = 4'd1;
      3'd7: c = 4'd9;
      default: c = 4'd8;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/stepper_bank_half_step_tracker_top.sv =====
// ----------------------------------------------------------------------------
// stepper_bank_half_step_tracker_top: half-step tracker for a stepper bank
// Holds position, target and phase per motor; ticks step all motors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one beat is a command. op selects tick,
//   set target, set position or read motor; in_motor picks the motor for set
//   and read; in_value carries the new target or position.
//   Output channel (out_valid/out_stall): a tick yields NUM_MOTORS beats in
//   motor order, out_last on the final one, out_moving set on all of them if
//   any motor stepped. A read yields one beat with moving low and last high.
//   Sets and commands for a missing motor yield nothing.
//   cfg_wr_en/cfg_wr_data write the reverse mask; write only while idle.
// Sequencing:
//   Commands wait in a four-entry queue. The back end takes a command in
//   IDLE and fetches from the stores in FETCH; in EXEC a set retires and a
//   read puts its beat in the output register once that register is free.
//   A tick streams one motor per cycle while the output is not stalled
//   (prefetch of motor i+1 overlaps the write-back of motor i); the single
//   read port of the stores sets that pace.
// Reset clears all motor state to zero and the mask; no clearing pass is
// needed. When out_stall is high the result and the tick sequence hold in
// place; the queue keeps taking commands until it fills.
// ----------------------------------------------------------------------------
module stepper_bank_half_step_tracker_top #(
  parameter int NUM_MOTORS = sbht_pkg::NUM_MOTORS_DEF,
  parameter int POS_WIDTH  = sbht_pkg::POS_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [sbht_pkg::MASK_W-1:0]   cfg_wr_data,
  // command beats
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sbht_pkg::OP_W-1:0]     in_op,
  input  logic [sbht_pkg::MOTOR_W-1:0]  in_motor,
  input  logic [sbht_pkg::VALUE_W-1:0]  in_value,
  // result beats
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sbht_pkg::MOTOR_W-1:0]  out_motor_index,
  output logic [sbht_pkg::COIL_W-1:0]   out_coil_pattern,
  output logic [sbht_pkg::VALUE_W-1:0]  out_position,
  output logic [sbht_pkg::VALUE_W-1:0]  out_target,
  output logic                          out_moving,
  output logic                          out_last
);

  localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int CMD_W = sbht_pkg::OP_W + IDX_W + POS_WIDTH;

  logic             q_push, q_pop, q_full, q_empty;
  logic [CMD_W-1:0] q_wdata, q_head;

  // front: classify and queue commands
  sbht_front #(.NUM_MOTORS(NUM_MOTORS), .POS_WIDTH(POS_WIDTH)) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_op    (in_op),
    .in_motor (in_motor),
    .in_value (in_value),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  // decouples command intake from tick streaming
  sbht_fifo #(.WIDTH(CMD_W), .DEPTH(sbht_pkg::CMD_FIFO_DEPTH)) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .head_data (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // back: stores, stepping datapath and output register
  sbht_back #(.NUM_MOTORS(NUM_MOTORS), .POS_WIDTH(POS_WIDTH)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .q_empty          (q_empty),
    .q_data           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_motor_index  (out_motor_index),
    .out_coil_pattern (out_coil_pattern),
    .out_position     (out_position),
    .out_target       (out_target),
    .out_moving       (out_moving),
    .out_last         (out_last)
  );

endmodule

// ===== rtl/sbht_ram.sv =====
// ----------------------------------------------------------------------------
// sbht_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data held when idle.
// ----------------------------------------------------------------------------
module sbht_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 22
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sbht_fifo.sv =====
// ----------------------------------------------------------------------------
// sbht_fifo: short command queue between front and back
// Registered storage, first-word-fall-through read.
// ----------------------------------------------------------------------------
module sbht_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = sbht_pkg::CMD_FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign empty     = (cnt_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/sbht_front.sv =====
// ----------------------------------------------------------------------------
// sbht_front: input beat acceptance and command classification
// Drops set/read beats aimed at a missing motor, packs the rest for the queue.
// ----------------------------------------------------------------------------
module sbht_front #(
  parameter int NUM_MOTORS = sbht_pkg::NUM_MOTORS_DEF,
  parameter int POS_WIDTH  = sbht_pkg::POS_WIDTH_DEF
) (
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [sbht_pkg::OP_W-1:0]                in_op,
  input  logic [sbht_pkg::MOTOR_W-1:0]             in_motor,
  input  logic [sbht_pkg::VALUE_W-1:0]             in_value,
  input  logic                                     q_full,
  output logic                                     q_push,
  output logic [sbht_pkg::OP_W + ((NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1)
                + POS_WIDTH - 1:0]                 q_data
);

  localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

  sbht_pkg::cmd_op_t                          op;
  logic                                       in_range;
  logic [IDX_W+sbht_pkg::MOTOR_W-1:0]         motor_ext;
  logic [POS_WIDTH+sbht_pkg::VALUE_W-1:0]     value_ext;

  assign op        = sbht_pkg::cmd_op_t'(in_op);
  assign in_range  = (32'(in_motor) < 32'(NUM_MOTORS));
  assign motor_ext = {{IDX_W{1'b0}}, in_motor};
  assign value_ext = {{POS_WIDTH{1'b0}}, in_value};

  assign in_stall = q_full;
  // Out-of-range set/read beats are accepted and dropped here.
  assign q_push   = in_valid && !q_full && ((op == sbht_pkg::OP_TICK) || in_range);
  assign q_data   = {in_op, motor_ext[IDX_W-1:0], value_ext[POS_WIDTH-1:0]};

endmodule

// ===== rtl/sbht_back.sv =====
// ----------------------------------------------------------------------------
// sbht_back: command execution over the motor stores
// Fetch/execute sequencer; a tick streams one motor per cycle unless stalled.
// ----------------------------------------------------------------------------
module sbht_back #(
  parameter int NUM_MOTORS = sbht_pkg::NUM_MOTORS_DEF,
  parameter int POS_WIDTH  = sbht_pkg::POS_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [sbht_pkg::MASK_W-1:0]         cfg_wr_data,
  input  logic                                q_empty,
  input  logic [sbht_pkg::OP_W + ((NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1)
                + POS_WIDTH - 1:0]            q_data,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sbht_pkg::MOTOR_W-1:0]        out_motor_index,
  output logic [sbht_pkg::COIL_W-1:0]         out_coil_pattern,
  output logic [sbht_pkg::VALUE_W-1:0]        out_position,
  output logic [sbht_pkg::VALUE_W-1:0]        out_target,
  output logic                                out_moving,
  output logic                                out_last
);

  localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int PH_W  = sbht_pkg::PHASE_W;
  localparam int OUT_W = sbht_pkg::VALUE_W;

  sbht_pkg::back_state_t state_r, state_nxt;

  sbht_pkg::cmd_op_t        op_r;
  logic [IDX_W-1:0]         cur_r;
  logic [POS_WIDTH-1:0]     val_r;
  logic                     moving_r;
  logic [sbht_pkg::MASK_W-1:0] rev_mask_r;
  logic [NUM_MOTORS-1:0]    pos_vld_r, tgt_vld_r, ph_vld_r;
  logic [NUM_MOTORS-1:0]    off_r;   // position != target, per motor

  // queue head
  sbht_pkg::cmd_op_t        cmd_op;
  logic [IDX_W-1:0]         cmd_idx;
  logic [POS_WIDTH-1:0]     cmd_val;

  // store read data
  logic [POS_WIDTH-1:0]     pos_q, tgt_q;
  logic [PH_W-1:0]          ph_q;
  logic [POS_WIDTH-1:0]     p, t;
  logic [PH_W-1:0]          ph;

  // step datapath
  logic                     differ, up, rev, fwd, is_last, out_free;
  logic [sbht_pkg::MASK_W-1:0] rev_sh;
  logic [POS_WIDTH-1:0]     p_step;
  logic [PH_W-1:0]          ph_step;
  logic [IDX_W-1:0]         cur_inc;

  // sequencer controls
  logic                     rd_en, pos_we, tgt_we, ph_we, off_we, off_val;
  logic                     out_load, advance;
  logic [IDX_W-1:0]         rd_addr;
  logic [POS_WIDTH-1:0]     pos_wd;
  logic [POS_WIDTH-1:0]     o_pos;
  logic [PH_W-1:0]          o_ph;
  logic                     o_moving, o_last;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic [sbht_pkg::MOTOR_W-1:0] out_idx_r;
  logic [sbht_pkg::COIL_W-1:0]  out_coil_r;
  logic [OUT_W-1:0]         out_pos_r, out_tgt_r;
  logic                     out_moving_r, out_last_r;
  logic [IDX_W+sbht_pkg::MOTOR_W-1:0] idx_ext;
  logic [POS_WIDTH+OUT_W-1:0]         pos_ext, tgt_ext;

  assign cmd_op  = sbht_pkg::cmd_op_t'(q_data[IDX_W+POS_WIDTH +: sbht_pkg::OP_W]);
  assign cmd_idx = q_data[POS_WIDTH +: IDX_W];
  assign cmd_val = q_data[POS_WIDTH-1:0];

  sbht_ram #(.WIDTH(POS_WIDTH), .DEPTH(NUM_MOTORS)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(cur_r), .wdata(pos_wd),
    .re(rd_en), .raddr(rd_addr), .rdata(pos_q)
  );

  sbht_ram #(.WIDTH(POS_WIDTH), .DEPTH(NUM_MOTORS)) u_tgt_ram (
    .clk(clk), .we(tgt_we), .waddr(cur_r), .wdata(val_r),
    .re(rd_en), .raddr(rd_addr), .rdata(tgt_q)
  );

  sbht_ram #(.WIDTH(PH_W), .DEPTH(NUM_MOTORS)) u_ph_ram (
    .clk(clk), .we(ph_we), .waddr(cur_r), .wdata(ph_step),
    .re(rd_en), .raddr(rd_addr), .rdata(ph_q)
  );

  // never-written entries read as zero
  assign p  = pos_vld_r[cur_r] ? pos_q : '0;
  assign t  = tgt_vld_r[cur_r] ? tgt_q : '0;
  assign ph = ph_vld_r[cur_r]  ? ph_q  : '0;

  assign differ  = (p != t);
  assign up      = (p < t);
  assign rev_sh  = rev_mask_r >> cur_r;
  assign rev     = rev_sh[0];
  assign fwd     = up ^ rev;
  assign p_step  = differ ? (up ? p + 1'b1 : p - 1'b1) : p;
  assign ph_step = differ ? (fwd ? ph + 1'b1 : ph - 1'b1) : ph;
  assign is_last = (cur_r == IDX_W'(NUM_MOTORS - 1));
  assign cur_inc = cur_r + 1'b1;
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sbht_pkg::ST_IDLE: begin
        if (!q_empty) state_nxt = sbht_pkg::ST_FETCH;
      end
      sbht_pkg::ST_FETCH: begin
        state_nxt = sbht_pkg::ST_EXEC;
      end
      sbht_pkg::ST_EXEC: begin
        unique case (op_r)
          sbht_pkg::OP_TICK: begin
            if (out_free && is_last) state_nxt = sbht_pkg::ST_IDLE;
          end
          sbht_pkg::OP_READ: begin
            if (out_free) state_nxt = sbht_pkg::ST_IDLE;
          end
          sbht_pkg::OP_SET_TGT,
          sbht_pkg::OP_SET_POS: begin
            state_nxt = sbht_pkg::ST_IDLE;
          end
          default: state_nxt = sbht_pkg::ST_IDLE;
        endcase
      end
      default: state_nxt = sbht_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_pop    = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = cur_r;
    pos_we   = 1'b0;
    pos_wd   = p_step;
    tgt_we   = 1'b0;
    ph_we    = 1'b0;
    off_we   = 1'b0;
    off_val  = differ;
    out_load = 1'b0;
    advance  = 1'b0;
    o_pos    = p;
    o_ph     = ph;
    o_moving = 1'b0;
    o_last   = 1'b1;
    unique case (state_r)
      sbht_pkg::ST_IDLE: begin
        q_pop = !q_empty;
      end
      sbht_pkg::ST_FETCH: begin
        rd_en = 1'b1;
      end
      sbht_pkg::ST_EXEC: begin
        unique case (op_r)
          sbht_pkg::OP_TICK: begin
            if (out_free) begin
              pos_we   = 1'b1;
              ph_we    = 1'b1;
              off_we   = 1'b1;
              off_val  = (p_step != t);
              out_load = 1'b1;
              o_pos    = p_step;
              o_ph     = ph_step;
              o_moving = moving_r;
              o_last   = is_last;
              if (!is_last) begin
                // prefetch the next motor while this one retires
                advance = 1'b1;
                rd_en   = 1'b1;
                rd_addr = cur_inc;
              end
            end
          end
          sbht_pkg::OP_SET_TGT: begin
            tgt_we  = 1'b1;
            off_we  = 1'b1;
            off_val = (p != val_r);
          end
          sbht_pkg::OP_SET_POS: begin
            pos_we  = 1'b1;
            pos_wd  = val_r;
            off_we  = 1'b1;
            off_val = (val_r != t);
          end
          sbht_pkg::OP_READ: begin
            out_load = out_free;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sbht_pkg::ST_IDLE;
      rev_mask_r <= '0;
      pos_vld_r  <= '0;
      tgt_vld_r  <= '0;
      ph_vld_r   <= '0;
      off_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) rev_mask_r <= cfg_wr_data;
      if (pos_we) pos_vld_r[cur_r] <= 1'b1;
      if (tgt_we) tgt_vld_r[cur_r] <= 1'b1;
      if (ph_we)  ph_vld_r[cur_r]  <= 1'b1;
      if (off_we) off_r[cur_r]     <= off_val;
    end
  end

  // command context
  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r     <= cmd_op;
      cur_r    <= (cmd_op == sbht_pkg::OP_TICK) ? '0 : cmd_idx;
      val_r    <= cmd_val;
      moving_r <= |off_r;
    end else if (advance) begin
      cur_r <= cur_inc;
    end
  end

  // output register
  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);
  assign idx_ext = {{sbht_pkg::MOTOR_W{1'b0}}, cur_r};
  assign pos_ext = {{OUT_W{1'b0}}, o_pos};
  assign tgt_ext = {{OUT_W{1'b0}}, t};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r    <= idx_ext[sbht_pkg::MOTOR_W-1:0];
      out_coil_r   <= sbht_pkg::coil_of(o_ph);
      out_pos_r    <= pos_ext[OUT_W-1:0];
      out_tgt_r    <= tgt_ext[OUT_W-1:0];
      out_moving_r <= o_moving;
      out_last_r   <= o_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_motor_index  = out_idx_r;
  assign out_coil_pattern = out_coil_r;
  assign out_position     = out_pos_r;
  assign out_target       = out_tgt_r;
  assign out_moving       = out_moving_r;
  assign out_last         = out_last_r;

endmodule

// ===== test/tb_stepper_bank_half_step_tracker_top.sv =====
// ----------------------------------------------------------------------------
// tb_stepper_bank_half_step_tracker_top: self-checking bench for the tracker
// Directed command table, then random set/read/tick traffic under several
// reverse masks and idle patterns; every result beat is scored in order
// against a hand-written result or a behavioral model of the motor bank.
// ----------------------------------------------------------------------------
module tb_stepper_bank_half_step_tracker_top;
  import sbht_pkg::*;

  localparam int MOTORS       = 22;
  localparam int PLAN_LEN     = 22;
  localparam int SEGMENTS     = 4;
  localparam int BEATS_PER_SEG = 100;  // useful commands per random segment
  localparam int DRAIN_CYCLES = 40;    // queued sets can still be retiring
  localparam int CYCLE_LIMIT  = 400000;

  // half-step coil drive by phase, bit 3 first coil
  localparam logic [COIL_W-1:0] COIL_BY_PHASE [8] = '{
    4'd8, 4'd12, 4'd4, 4'd6, 4'd2, 4'd3, 4'd1, 4'd9
  };

  typedef struct packed {
    logic [MOTOR_W-1:0] idx;
    logic [COIL_W-1:0]  coil;
    logic [VALUE_W-1:0] pos;
    logic [VALUE_W-1:0] tgt;
    logic               moving;
    logic               last;
  } motor_beat_t;

  typedef struct packed {
    cmd_op_t            op;
    logic [MOTOR_W-1:0] motor;
    logic [VALUE_W-1:0] value;
    logic               typed;  // want holds a hand-written result
    motor_beat_t        want;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [MASK_W-1:0] cfg_wr_data;
  logic in_valid;
  logic in_stall;
  logic [OP_W-1:0] in_op;
  logic [MOTOR_W-1:0] in_motor;
  logic [VALUE_W-1:0] in_value;
  logic out_valid;
  logic out_stall;
  logic [MOTOR_W-1:0] out_motor_index;
  logic [COIL_W-1:0] out_coil_pattern;
  logic [VALUE_W-1:0] out_position;
  logic [VALUE_W-1:0] out_target;
  logic out_moving;
  logic out_last;

  stepper_bank_half_step_tracker_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_motor         (in_motor),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_motor_index  (out_motor_index),
    .out_coil_pattern (out_coil_pattern),
    .out_position     (out_position),
    .out_target       (out_target),
    .out_moving       (out_moving),
    .out_last         (out_last)
  );

  // Shadow copy of the bank. Updated when a command beat is accepted, so
  // its contents always match what the back end will see for that command.
  logic [VALUE_W-1:0] shadow_pos   [MOTORS];
  logic [VALUE_W-1:0] shadow_tgt   [MOTORS];
  logic [PHASE_W-1:0] shadow_phase [MOTORS];
  logic [MASK_W-1:0]  shadow_reverse;

  motor_beat_t pending_beats[$];   // result beats still owed, oldest first
  int unsigned mismatches;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_count;

  plan_row_t plan [PLAN_LEN];

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Run one command through the shadow bank; the beats it produces land in
  // produced, in the order the block must emit them.
  function automatic void step_bank(input cmd_op_t op, input logic [MOTOR_W-1:0] m,
                                    input logic [VALUE_W-1:0] v,
                                    ref motor_beat_t produced[$]);
    logic any_step;
    logic up;
    motor_beat_t b;
    produced.delete();
    if (op == OP_TICK) begin
      any_step = 1'b0;
      for (int i = 0; i < MOTORS; i++) begin
        if (shadow_pos[i] != shadow_tgt[i]) begin
          up = shadow_pos[i] < shadow_tgt[i];
          // a set reverse bit flips which way the phase walks
          if (up ^ shadow_reverse[i]) shadow_phase[i] = shadow_phase[i] + 3'd1;
          else                        shadow_phase[i] = shadow_phase[i] - 3'd1;
          shadow_pos[i] = up ? shadow_pos[i] + 16'd1 : shadow_pos[i] - 16'd1;
          any_step = 1'b1;
        end
      end
      for (int i = 0; i < MOTORS; i++) begin
        b.idx    = MOTOR_W'(i);
        b.coil   = COIL_BY_PHASE[shadow_phase[i]];
        b.pos    = shadow_pos[i];
        b.tgt    = shadow_tgt[i];
        b.moving = any_step;
        b.last   = (i == MOTORS - 1);
        produced.push_back(b);
      end
    end else if (m < MOTORS) begin
      // commands naming a motor past the bank are dropped silently
      case (op)
        OP_SET_TGT: shadow_tgt[m] = v;
        OP_SET_POS: shadow_pos[m] = v;
        default: begin
          b.idx    = m;
          b.coil   = COIL_BY_PHASE[shadow_phase[m]];
          b.pos    = shadow_pos[m];
          b.tgt    = shadow_tgt[m];
          b.moving = 1'b0;
          b.last   = 1'b1;
          produced.push_back(b);
        end
      endcase
    end
  endfunction

  function automatic void check_field(input string name, input logic [VALUE_W-1:0] want,
                                      input logic [VALUE_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Present one command beat and hold it until accepted. Valid stays high
  // across back-to-back beats; an idle gap lowers it for whole cycles.
  task automatic send_command(input cmd_op_t op, input logic [MOTOR_W-1:0] m,
                              input logic [VALUE_W-1:0] v, input logic typed,
                              input motor_beat_t want);
    motor_beat_t produced[$];
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_motor <= m;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted on this edge
    step_bank(op, m, v, produced);
    if (typed) pending_beats.push_back(want);
    else foreach (produced[k]) pending_beats.push_back(produced[k]);
  endtask

  // Stop sending and wait until every owed beat is back, then a little
  // longer for sets that are still draining out of the command queue.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reverse(input logic [MASK_W-1:0] mask);
    wait_quiet();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mask;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_reverse = mask;
  endtask

  task automatic send_random();
    int unsigned pick;
    cmd_op_t op;
    logic [MOTOR_W-1:0] m;
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] near;
    pick = $urandom_range(99);
    if (pick < 35)      op = OP_TICK;
    else if (pick < 60) op = OP_SET_TGT;
    else if (pick < 75) op = OP_SET_POS;
    else                op = OP_READ;
    // mostly real motors, now and then a number past the end of the bank
    m = ($urandom_range(9) == 0) ? MOTOR_W'($urandom_range(31, MOTORS))
                                 : MOTOR_W'($urandom_range(MOTORS - 1));
    near = (m < MOTORS) ? shadow_pos[m] : '0;
    case ($urandom_range(3))
      0:       v = VALUE_W'($urandom);
      1, 2:    v = near + VALUE_W'($urandom_range(8)) - 16'd4;  // reachable in a few ticks
      default: v = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endcase
    send_command(op, m, v, 1'b0, '0);
  endtask

  // Result side: score accepted beats and pick the next stall at random.
  always @(posedge clk) begin
    motor_beat_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_beats.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected beat, expected none, actual motor %0d", $time,
                   out_motor_index);
        end else begin
          want = pending_beats.pop_front();
          check_field("motor_index",  want.idx,    out_motor_index);
          check_field("coil_pattern", want.coil,   out_coil_pattern);
          check_field("position",     want.pos,    out_position);
          check_field("target",       want.tgt,    out_target);
          check_field("moving",       want.moving, out_moving);
          check_field("last",         want.last,   out_last);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: a hung handshake or a missing beat ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int unsigned useful;
    logic [MASK_W-1:0] mask;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_op          = OP_TICK;
    in_motor       = '0;
    in_value       = '0;
    out_stall      = 1'b0;
    mismatches     = 0;
    cycle_count    = 0;
    send_gap_pct   = 33;
    recv_stall_pct = 55;
    shadow_reverse = '0;
    for (int i = 0; i < MOTORS; i++) begin
      shadow_pos[i]   = '0;
      shadow_tgt[i]   = '0;
      shadow_phase[i] = '0;
    end

    // Directed table. Typed rows carry a result readable by eye: the reset
    // state, one step up into the top of the range, one step down to zero,
    // and a step down from the top. Others are scored by the shadow bank.
    plan = '{
      '{OP_READ,    5'd0,  16'h0000, 1'b1, '{5'd0,  4'd8,  16'h0000, 16'h0000, 1'b0, 1'b1}},
      '{OP_READ,    5'd21, 16'h0000, 1'b1, '{5'd21, 4'd8,  16'h0000, 16'h0000, 1'b0, 1'b1}},
      '{OP_READ,    5'd22, 16'h0000, 1'b0, '0},  // past the bank: no beat
      '{OP_READ,    5'd31, 16'hFFFF, 1'b0, '0},
      '{OP_SET_TGT, 5'd31, 16'hFFFF, 1'b0, '0},  // dropped set
      '{OP_SET_POS, 5'd22, 16'h04D2, 1'b0, '0},
      '{OP_TICK,    5'd0,  16'h0000, 1'b0, '0},  // all on target: moving low
      '{OP_SET_TGT, 5'd0,  16'hFFFF, 1'b0, '0},
      '{OP_SET_POS, 5'd0,  16'hFFFE, 1'b0, '0},
      '{OP_SET_TGT, 5'd21, 16'h0000, 1'b0, '0},
      '{OP_SET_POS, 5'd21, 16'h0001, 1'b0, '0},
      '{OP_SET_POS, 5'd5,  16'hAAAA, 1'b0, '0},
      '{OP_SET_TGT, 5'd5,  16'h5555, 1'b0, '0},
      '{OP_TICK,    5'd31, 16'hFFFF, 1'b0, '0},
      '{OP_READ,    5'd0,  16'h0000, 1'b1, '{5'd0,  4'd12, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1}},
      '{OP_READ,    5'd21, 16'h0000, 1'b1, '{5'd21, 4'd9,  16'h0000, 16'h0000, 1'b0, 1'b1}},
      '{OP_TICK,    5'd10, 16'h5555, 1'b0, '0},  // motor 0 now parked on target
      '{OP_SET_POS, 5'd10, 16'hFFFF, 1'b0, '0},
      '{OP_SET_TGT, 5'd10, 16'h0000, 1'b0, '0},
      '{OP_TICK,    5'd0,  16'h0000, 1'b0, '0},
      '{OP_READ,    5'd10, 16'h0000, 1'b1, '{5'd10, 4'd9,  16'hFFFE, 16'h0000, 1'b0, 1'b1}},
      '{OP_READ,    5'd5,  16'hAAAA, 1'b0, '0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reverse('0);
    foreach (plan[r])
      send_command(plan[r].op, plan[r].motor, plan[r].value, plan[r].typed, plan[r].want);

    // Random segments: all-reverse, two random masks, back to none. Idle
    // mix goes sender-light/receiver-heavy, swapped, then none at all.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0:       mask = '1;
        3:       mask = '0;
        default: mask = MASK_W'($urandom);
      endcase
      write_reverse(mask);
      case (seg)
        0: begin
          send_gap_pct   = 33;
          recv_stall_pct = 55;
        end
        1: begin
          send_gap_pct   = 55;
          recv_stall_pct = 33;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      useful = 0;
      while (useful < BEATS_PER_SEG) begin
        send_random();
        // commands aimed past the bank do nothing, so they are not counted
        if (in_op == OP_TICK || in_motor < MOTORS) useful++;
      end
    end

    wait_quiet();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sbht_pkg.sv
rtl/sbht_ram.sv
rtl/sbht_fifo.sv
rtl/sbht_front.sv
rtl/sbht_back.sv
rtl/stepper_bank_half_step_tracker_top.sv
test/tb_stepper_bank_half_step_tracker_top.sv
